// File: sv/coab_pkg.sv
package coab_pkg;

   // Shape store geometry
   localparam int unsigned STORE_AW = 12;
   localparam int unsigned WORD_W   = 32;

   // Register index codes (byte address / 4)
   localparam int unsigned REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_VISIBLE  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SHAPE_W  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SHAPE_H  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_FB_W     = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_FB_H     = 3'd6;

   localparam int unsigned CSR_AW = 5;
   localparam int unsigned CSR_DW = 32;

   // Register reset values
   localparam logic [6:0]  SHAPE_W_RST = 7'd12;
   localparam logic [6:0]  SHAPE_H_RST = 7'd19;
   localparam logic [12:0] FB_W_RST    = 13'd4096;
   localparam logic [12:0] FB_H_RST    = 13'd4096;

   // Request operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_BLEND = 1'b1;

   // Blend constants
   localparam logic [7:0] BYTE_MAX  = 8'hFF;
   localparam int unsigned ALPHA_LSB = 24;

   typedef struct packed {
      logic        operation;
      logic [11:0] shape_index;
      logic [31:0] shape_argb;
      logic [11:0] pixel_col;
      logic [11:0] pixel_row;
      logic [7:0]  in_blue;
      logic [7:0]  in_green;
      logic [7:0]  in_red;
      logic [7:0]  in_pad;
   } req_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic [7:0] out_pad;
      logic       covered;
   } rsp_type;

   typedef struct packed {
      logic               cursor_visible;
      logic signed [12:0] origin_x;
      logic signed [12:0] origin_y;
      logic [6:0]         shape_width;
      logic [6:0]         shape_height;
      logic [12:0]        fb_width;
      logic [12:0]        fb_height;
   } cfg_type;

endpackage

// File: sv/coab_csr.sv
module coab_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [coab_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [coab_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [coab_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready,
   output coab_pkg::cfg_type           cfg
);

   coab_pkg::cfg_type                  cfg_ff;
   logic                               wr_en;
   logic [coab_pkg::REG_IDX_W-1:0]     reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[coab_pkg::CSR_AW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // Register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cursor_visible <= 1'b0;
         cfg_ff.origin_x       <= '0;
         cfg_ff.origin_y       <= '0;
         cfg_ff.shape_width    <= coab_pkg::SHAPE_W_RST;
         cfg_ff.shape_height   <= coab_pkg::SHAPE_H_RST;
         cfg_ff.fb_width       <= coab_pkg::FB_W_RST;
         cfg_ff.fb_height      <= coab_pkg::FB_H_RST;
      end else if (wr_en) begin
         case (reg_idx)
            coab_pkg::REG_VISIBLE:  cfg_ff.cursor_visible <= csr_pwdata[0];
            coab_pkg::REG_ORIGIN_X: cfg_ff.origin_x       <= csr_pwdata[12:0];
            coab_pkg::REG_ORIGIN_Y: cfg_ff.origin_y       <= csr_pwdata[12:0];
            coab_pkg::REG_SHAPE_W:  cfg_ff.shape_width    <= csr_pwdata[6:0];
            coab_pkg::REG_SHAPE_H:  cfg_ff.shape_height   <= csr_pwdata[6:0];
            coab_pkg::REG_FB_W:     cfg_ff.fb_width       <= csr_pwdata[12:0];
            coab_pkg::REG_FB_H:     cfg_ff.fb_height      <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   // Read mux, raw register bits zero extended
   always_comb begin
      case (reg_idx)
         coab_pkg::REG_VISIBLE:  csr_prdata = 32'(cfg_ff.cursor_visible);
         coab_pkg::REG_ORIGIN_X: csr_prdata = 32'(unsigned'(cfg_ff.origin_x));
         coab_pkg::REG_ORIGIN_Y: csr_prdata = 32'(unsigned'(cfg_ff.origin_y));
         coab_pkg::REG_SHAPE_W:  csr_prdata = 32'(cfg_ff.shape_width);
         coab_pkg::REG_SHAPE_H:  csr_prdata = 32'(cfg_ff.shape_height);
         coab_pkg::REG_FB_W:     csr_prdata = 32'(cfg_ff.fb_width);
         coab_pkg::REG_FB_H:     csr_prdata = 32'(cfg_ff.fb_height);
         default:                csr_prdata = '0;
      endcase
   end

endmodule

// File: sv/cursor_overlay_alpha_blend.sv
// Channel   | direction | handshake                | payload
// req_      | in        | req_valid / req_stall    | req_data (coab_pkg::req_type)
// rsp_      | out       | rsp_valid / rsp_stall    | rsp_data (coab_pkg::rsp_type)
// csr_      | in/out    | APB psel/penable/pready  | 7 regs at byte address 4*i
//
// Five register stages: hit test, store index, shape store, multiply, divide/add.
// One request per clock while the output is not stalled; a blend result leaves from the divide/add stage.
// Load requests write the shape store in stage 3 and give no result.
// Synchronous active-high reset sets the config registers to their reset values and clears all stage valid bits;
// the shape store is not cleared. Each stage holds while the next one is full
// and stalled, so empty stages still fill while the output is stalled.
module cursor_overlay_alpha_blend #(
   parameter int unsigned MAX_SHAPE_SIDE = 64,
   parameter int unsigned MAX_FRAME_SIDE = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  coab_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output coab_pkg::rsp_type           rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [coab_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [coab_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [coab_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);

   localparam int unsigned SWB = $clog2(MAX_SHAPE_SIDE + 1);
   localparam int unsigned FWB = $clog2(MAX_FRAME_SIDE + 1);
   localparam int unsigned AW  = coab_pkg::STORE_AW;
   localparam int unsigned DW  = coab_pkg::WORD_W;

   coab_pkg::cfg_type cfg;

   coab_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Clamped sizes (the user must keep config static while requests are in flight; the block does not enforce it)
   logic [SWB-1:0] sw_eff;
   logic [SWB-1:0] sh_eff;
   logic [FWB-1:0] fw_eff;
   logic [FWB-1:0] fh_eff;

   always_comb begin
      sw_eff = (32'(cfg.shape_width) > 32'(MAX_SHAPE_SIDE)) ?
               SWB'(MAX_SHAPE_SIDE) : SWB'(cfg.shape_width);
      sh_eff = (32'(cfg.shape_height) > 32'(MAX_SHAPE_SIDE)) ?
               SWB'(MAX_SHAPE_SIDE) : SWB'(cfg.shape_height);
      fw_eff = (32'(cfg.fb_width) > 32'(MAX_FRAME_SIDE)) ?
               FWB'(MAX_FRAME_SIDE) : FWB'(cfg.fb_width);
      fh_eff = (32'(cfg.fb_height) > 32'(MAX_FRAME_SIDE)) ?
               FWB'(MAX_FRAME_SIDE) : FWB'(cfg.fb_height);
   end

   // Stage valid bits and ready chain
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   assign rdy5      = !v5_ff || !rsp_stall;
   assign rdy4      = !v4_ff || rdy5;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   logic acc;
   assign acc = req_valid && rdy1;

   // Stage 1: offsets and rectangle / frame test
   logic signed [13:0] dx_in, dy_in;
   logic               inside_in;
   logic               s1_op_ff;
   logic [AW-1:0]      s1_sidx_ff;
   logic [DW-1:0]      s1_argb_ff;
   logic [AW-1:0]      s1_dx_ff, s1_dy_ff;
   logic               s1_inside_ff;
   logic [31:0]        s1_pix_ff;

   always_comb begin
      dx_in = $signed({2'b00, req_data.pixel_col}) -
              $signed({cfg.origin_x[12], cfg.origin_x});
      dy_in = $signed({2'b00, req_data.pixel_row}) -
              $signed({cfg.origin_y[12], cfg.origin_y});
      inside_in = cfg.cursor_visible &&
                  (32'(req_data.pixel_col) < 32'(fw_eff)) &&
                  (32'(req_data.pixel_row) < 32'(fh_eff)) &&
                  !dx_in[13] && !dy_in[13] &&
                  (32'(dx_in[12:0]) < 32'(sw_eff)) &&
                  (32'(dy_in[12:0]) < 32'(sh_eff));
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_op_ff     <= req_data.operation;
         s1_sidx_ff   <= req_data.shape_index;
         s1_argb_ff   <= req_data.shape_argb;
         s1_dx_ff     <= dx_in[AW-1:0];
         s1_dy_ff     <= dy_in[AW-1:0];
         s1_inside_ff <= inside_in;
         s1_pix_ff    <= {req_data.in_blue, req_data.in_green,
                          req_data.in_red, req_data.in_pad};
      end
   end

   // Stage 2: store address (row * width + col for blends, wraps to store size; shape index for loads)
   logic [31:0]   prod_in;
   logic [AW-1:0] addr_in;
   logic          s2_op_ff;
   logic [AW-1:0] s2_addr_ff;
   logic [DW-1:0] s2_argb_ff;
   logic          s2_inside_ff;
   logic [31:0]   s2_pix_ff;

   always_comb begin
      prod_in = 32'(s1_dy_ff) * 32'(sw_eff);
      addr_in = (s1_op_ff == coab_pkg::OP_LOAD) ? s1_sidx_ff :
                AW'(prod_in + 32'(s1_dx_ff));
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_op_ff     <= s1_op_ff;
         s2_addr_ff   <= addr_in;
         s2_argb_ff   <= s1_argb_ff;
         s2_inside_ff <= s1_inside_ff;
         s2_pix_ff    <= s1_pix_ff;
      end
   end

   // Stage 3: shape store, one access per cycle while stage 3 is not stalled, kept in request order
   logic [DW-1:0] shape_mem [2**AW];
   logic [DW-1:0] s3_word_ff;
   logic          s3_inside_ff;
   logic [31:0]   s3_pix_ff;
   logic          s2_adv;

   assign s2_adv = v2_ff && rdy3;

   always_ff @(posedge clock) begin
      if (s2_adv && (s2_op_ff == coab_pkg::OP_LOAD)) begin
         shape_mem[s2_addr_ff] <= s2_argb_ff;
      end
      if (rdy3) begin
         s3_word_ff <= shape_mem[s2_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_inside_ff <= s2_inside_ff;
         s3_pix_ff    <= s2_pix_ff;
      end
   end

   // Stage 4: dst * (255 - alpha) per channel
   logic [7:0]  alpha;
   logic [7:0]  inv;
   logic        hit_in;
   logic [15:0] pb_in, pg_in, pr_in;
   logic        s4_hit_ff;
   logic [23:0] s4_src_ff;
   logic [31:0] s4_pix_ff;
   logic [15:0] s4_pb_ff, s4_pg_ff, s4_pr_ff;

   always_comb begin
      alpha  = s3_word_ff[coab_pkg::ALPHA_LSB +: 8];
      inv    = coab_pkg::BYTE_MAX - alpha;
      hit_in = s3_inside_ff && (alpha != 8'd0);
      pb_in  = 16'(s3_pix_ff[31:24]) * 16'(inv);
      pg_in  = 16'(s3_pix_ff[23:16]) * 16'(inv);
      pr_in  = 16'(s3_pix_ff[15:8]) * 16'(inv);
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_hit_ff <= hit_in;
         s4_src_ff <= s3_word_ff[23:0];
         s4_pix_ff <= s3_pix_ff;
         s4_pb_ff  <= pb_in;
         s4_pg_ff  <= pg_in;
         s4_pr_ff  <= pr_in;
      end
   end

   // Stage 5: exact divide by 255 via (p + (p >> 8) + 1) >> 8, then add; a miss passes the pixel through
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] t;
      t = 17'(p) + 17'(p >> 8) + 17'd1;
      return t[15:8];
   endfunction

   coab_pkg::rsp_type rsp_in;
   coab_pkg::rsp_type rsp_ff;

   always_comb begin
      rsp_in.out_pad = s4_pix_ff[7:0];
      rsp_in.covered = s4_hit_ff;
      if (s4_hit_ff) begin
         rsp_in.out_blue  = s4_src_ff[7:0] + div255(s4_pb_ff);
         rsp_in.out_green = s4_src_ff[15:8] + div255(s4_pg_ff);
         rsp_in.out_red   = s4_src_ff[23:16] + div255(s4_pr_ff);
      end else begin
         rsp_in.out_blue  = s4_pix_ff[31:24];
         rsp_in.out_green = s4_pix_ff[23:16];
         rsp_in.out_red   = s4_pix_ff[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         rsp_ff <= rsp_in;
      end
   end

   // Valid bits; load requests retire in stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= acc;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff && (s2_op_ff == coab_pkg::OP_BLEND);
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   assign rsp_valid = v5_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // A load never produces a result
   a_load_retires: assert property (@(posedge clock) disable iff (reset)
      s2_adv && (s2_op_ff == coab_pkg::OP_LOAD) |=> !v3_ff)
      else $error("load request entered the blend stages");

   // Input stalls only when every stage is occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff))
      else $error("input stalled with an empty stage");

   // A blocked multiply stage keeps its item and products
   a_s4_hold: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !rdy5 |=> v4_ff && $stable(s4_pb_ff) && $stable(s4_hit_ff))
      else $error("stage 4 lost or changed a stalled item");

   // Coverage requires the cursor to be enabled
   a_cover_visible: assert property (@(posedge clock) disable iff (reset)
      v4_ff && s4_hit_ff |-> cfg.cursor_visible)
      else $error("pixel covered while cursor hidden");
`endif

endmodule
